>>> hdl/pnih_pkg.sv
// ----------------------------------------------------------------------------
// pnih_pkg
// shared constants, types and helper functions of the path name inode hash
// ----------------------------------------------------------------------------
package pnih_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned INODE_W  = 31;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = 1;
  localparam int unsigned QCNT_W   = 2;

  localparam logic [HASH_W-1:0]  HASH_MODULUS    = 32'd2147482949;
  localparam logic [HASH_W-1:0]  HASH_MODULUS_X2 = 32'd4294965898;
  localparam logic [INODE_W-1:0] ROOT_INODE      = 31'd2;
  localparam logic [4:0]         ROT_STEP        = 5'd5;
  localparam logic [4:0]         MOD_BASE        = 5'd31;
  localparam logic [CNT_W-1:0]   CNT_SAT         = 3'd4;
  localparam logic [CNT_W-1:0]   CNT_ROOT        = 3'd3;
  localparam logic [CNT_W-1:0]   CNT_SECOND      = 3'd1;
  localparam logic [CNT_W-1:0]   CNT_THIRD       = 3'd2;

  localparam logic [BYTE_W-1:0] CHAR_LOWER_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_Z  = 8'h7a;
  localparam logic [BYTE_W-1:0] CHAR_CASE_BIT = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_SLASH    = 8'h2f;
  localparam logic [BYTE_W-1:0] CHAR_BSLASH   = 8'h5c;
  localparam logic [BYTE_W-1:0] CHAR_COLON    = 8'h3a;

  typedef struct packed {
    logic [HASH_W-1:0] mixed;
    logic              root;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_wr_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_rd_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] f;
    f = b;
    if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
      f = b - CHAR_CASE_BIT;
    end else if (b == CHAR_SLASH) begin
      f = CHAR_BSLASH;
    end
    return f;
  endfunction

  // 32 = 31 + 1, so b mod 31 = (high3 + low5) mod 31 with one correction
  function automatic logic [4:0] mod31(input logic [BYTE_W-1:0] b);
    logic [5:0] s;
    logic [5:0] t;
    s = {3'd0, b[7:5]} + {1'b0, b[4:0]};
    t = s - {1'b0, MOD_BASE};
    return (s >= {1'b0, MOD_BASE}) ? t[4:0] : s[4:0];
  endfunction

  function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] v,
                                             input logic [4:0] n);
    logic [2*HASH_W-1:0] d;
    d = {v, v} << n;
    return d[2*HASH_W-1:HASH_W];
  endfunction

endpackage

>>> hdl/pnih_front.sv
// ----------------------------------------------------------------------------
// pnih_front
// takes path bytes, folds them and updates the hash and mix accumulators;
// on the last byte pushes the combined value and the drive root flag
// ----------------------------------------------------------------------------
module pnih_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [pnih_pkg::BYTE_W-1:0]   in_path_byte,
  input  logic                          in_last_byte,
  input  logic                          q_full,
  output pnih_pkg::q_wr_t               q_wr
);
  import pnih_pkg::*;

  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [HASH_W-1:0] mix_r, mix_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              colon_r, colon_nxt;
  logic              bslash_r, bslash_nxt;
  logic [BYTE_W-1:0] folded;
  logic              accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  always_comb begin
    folded     = fold_byte(in_path_byte);
    hash_nxt   = rotl(hash_r, ROT_STEP) ^ {{(HASH_W-BYTE_W){1'b0}}, folded};
    mix_nxt    = mix_r ^ rotl(hash_nxt, mod31(folded));
    colon_nxt  = (cnt_r == CNT_SECOND) ? (in_path_byte == CHAR_COLON) : colon_r;
    bslash_nxt = (cnt_r == CNT_THIRD) ? (in_path_byte == CHAR_BSLASH) : bslash_r;
    cnt_nxt    = (cnt_r < CNT_SAT) ? cnt_r + 3'd1 : cnt_r;
  end

  always_comb begin
    q_wr.push        = accept && in_last_byte;
    q_wr.entry.mixed = hash_nxt ^ mix_nxt;
    q_wr.entry.root  = (cnt_nxt == CNT_ROOT) && colon_nxt && bslash_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r   <= '0;
      mix_r    <= '0;
      cnt_r    <= '0;
      colon_r  <= 1'b0;
      bslash_r <= 1'b0;
    end else if (accept) begin
      if (in_last_byte) begin
        hash_r   <= '0;
        mix_r    <= '0;
        cnt_r    <= '0;
        colon_r  <= 1'b0;
        bslash_r <= 1'b0;
      end else begin
        hash_r   <= hash_nxt;
        mix_r    <= mix_nxt;
        cnt_r    <= cnt_nxt;
        colon_r  <= colon_nxt;
        bslash_r <= bslash_nxt;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_byte) |=> (cnt_r == '0 && hash_r == '0 && mix_r == '0))
    else $error("front state not cleared after last byte");

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_SAT)
    else $error("byte count beyond saturation");

  a_root_short: assert property (@(posedge clk) disable iff (!rst_n)
    (q_wr.push && q_wr.entry.root) |-> (cnt_r == CNT_THIRD))
    else $error("drive root flagged on a path that is not three bytes");

endmodule

>>> hdl/pnih_queue.sv
// ----------------------------------------------------------------------------
// pnih_queue
// short queue between the hashing front and the reducing back
// ----------------------------------------------------------------------------
module pnih_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  pnih_pkg::q_wr_t   q_wr,
  output logic              q_full,
  output pnih_pkg::q_rd_t   q_rd,
  input  logic              q_pop
);
  import pnih_pkg::*;

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign q_full       = (cnt_r == QCNT_W'(QDEPTH));
  assign q_rd.valid   = (cnt_r != '0);
  assign q_rd.entry   = mem_r[rd_ptr_r];
  assign do_push      = q_wr.push && !q_full;
  assign do_pop       = q_pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_wr.push && q_full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_rd.valid)
    else $error("pop from empty queue");

endmodule

>>> hdl/pnih_back.sv
// ----------------------------------------------------------------------------
// pnih_back
// reduces the combined hash modulo the inode modulus, or gives the root inode
// for a drive root, and holds the result in the output register
// ----------------------------------------------------------------------------
module pnih_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pnih_pkg::q_rd_t              q_rd,
  output logic                         q_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [pnih_pkg::INODE_W-1:0] out_inode_number
);
  import pnih_pkg::*;

  logic                 out_valid_r;
  logic [INODE_W-1:0]   inode_r, inode_nxt;
  logic [HASH_W-1:0]    sub1, sub2;
  logic                 take;

  assign out_empty        = !out_valid_r;
  assign out_inode_number = inode_r;
  assign take             = q_rd.valid && (!out_valid_r || out_pop);
  assign q_pop            = take;

  // value is below twice the modulus plus a little, so at most two subtracts
  always_comb begin
    sub1 = q_rd.entry.mixed - HASH_MODULUS;
    sub2 = q_rd.entry.mixed - HASH_MODULUS_X2;
    priority if (q_rd.entry.root) begin
      inode_nxt = ROOT_INODE;
    end else if (q_rd.entry.mixed >= HASH_MODULUS_X2) begin
      inode_nxt = sub2[INODE_W-1:0];
    end else if (q_rd.entry.mixed >= HASH_MODULUS) begin
      inode_nxt = sub1[INODE_W-1:0];
    end else begin
      inode_nxt = q_rd.entry.mixed[INODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      inode_r <= inode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, inode_r} < HASH_MODULUS))
    else $error("inode number not reduced");

  a_root_value: assert property (@(posedge clk) disable iff (!rst_n)
    (take && q_rd.entry.root) |=> (inode_r == ROOT_INODE))
    else $error("drive root not answered with root inode");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pop && !q_rd.valid) |=> !out_valid_r)
    else $error("output beat repeated");

endmodule

>>> hdl/path_name_inode_hash.sv
// ----------------------------------------------------------------------------
// path_name_inode_hash
// hashes a path name, one byte a beat, into a 31-bit inode number
// ----------------------------------------------------------------------------
// One byte is accepted every cycle while in_full is low; the per-byte fold,
// rotates and XORs of the hashing front finish in the cycle of the beat. The
// result of a path is written into the two-entry queue on its last byte, then
// the modulus reduction loads it into the output register. in_full rises only
// when the queue is full, which happens only while results are left waiting on
// the output side.
module path_name_inode_hash (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [pnih_pkg::BYTE_W-1:0]  in_path_byte,
  input  logic                         in_last_byte,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [pnih_pkg::INODE_W-1:0] out_inode_number
);
  import pnih_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  pnih_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_path_byte (in_path_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_wr         (q_wr)
  );

  pnih_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  pnih_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_rd             (q_rd),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_inode_number (out_inode_number)
  );

endmodule
